@@ rtl/core/urc_pkg.sv @@
// Package for the use-rate cache: sizes, codes, item and entry types, sequencer states.
// No dependencies. The top level and the checker under rtl/core import it.
package urc_pkg;

	localparam int ENTRIES  = 30;
	localparam int SLOT_W   = 5;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 32;
	localparam int TIME_W   = 48;
	localparam int HALF_W   = TIME_W / 2;
	localparam int PROD_W   = CNT_W + HALF_W;
	localparam int WIDE_W   = CNT_W + TIME_W;
	localparam int STEP_W   = 3;
	localparam logic [STEP_W-1:0] MUL_STEPS = 3'd4;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
	localparam logic [SLOT_W-1:0] SLOT_NUM  = SLOT_W'(ENTRIES);

	localparam logic KIND_LOOKUP  = 1'b0;
	localparam logic KIND_RECYCLE = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_SLT = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] target_slot;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
		logic              status;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  cnt;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_INS,
		ST_EV_RD,
		ST_EV_AGE,
		ST_EV_MUL,
		ST_EV_CMP,
		ST_RC_RD,
		ST_RC_WR
	} state_t;

	typedef struct packed {
		logic              ram_re;
		logic [SLOT_W-1:0] ram_raddr;
		logic              ram_we;
		logic [SLOT_W-1:0] ram_waddr;
		entry_t            ram_wdata;
		logic              finish;
		result_t           res;
	} ctl_t;

endpackage

@@ rtl/core/urc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; width and depth come from parameters.
module urc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/usage_rate_cache_replacement_top.sv @@
// Use-rate cache, top level: item capture, sequencer, rate compare datapath, result register.
// Depends on urc_pkg and urc_ram.
//
// An empty or out-of-range recycle is answered from idle; a valid recycle reads the entry and
// writes it back. A lookup makes one key compare per cycle and stops at a hit; an insert into a
// free slot follows the full scan. An insert into a full cache runs 29 rate compares, each on
// the one shared 32x24 multiplier and the single entry RAM read port.
// One item at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset clears all valid bits at once; entry data stays as it was.
module usage_rate_cache_replacement_top
	import urc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	state_t state_q, state_d;
	ctl_t   ctl;

	cmd_t               cmd_q;
	logic [ENTRIES-1:0] valid_q;
	logic [SLOT_W-1:0]  idx_q;
	logic               cmp_vld_s1;
	logic [SLOT_W-1:0]  cmp_idx_s1;
	logic               free_found_q;
	logic [SLOT_W-1:0]  free_idx_q;
	logic [SLOT_W-1:0]  ins_slot_q;
	logic               ev_q;
	logic [STEP_W-1:0]  step_q;

	// best candidate so far and the entry under test
	logic [SLOT_W-1:0]  best_idx_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [TIME_W-1:0]  best_age_q;
	logic [KEY_W-1:0]   cand_key_q;
	logic [CNT_W-1:0]   cand_cnt_q;
	logic [TIME_W-1:0]  cand_age_q;

	// shared multiplier and partial product accumulation
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  lo_q;
	logic [WIDE_W-1:0]  p1_q;
	logic [WIDE_W-1:0]  p2_q;

	entry_t             rd_entry;
	logic [$bits(entry_t)-1:0] rdata;

	logic               accept;
	logic               tgt_ok;
	logic               hit_now;
	logic               free_now;
	logic               scan_cmp;
	logic [TIME_W-1:0]  age_d;
	logic [CNT_W-1:0]   mul_a;
	logic [TIME_W-1:0]  mul_bsrc;
	logic [HALF_W-1:0]  mul_b;
	logic [PROD_W-1:0]  prod_d;
	logic [WIDE_W-1:0]  wide_sum;
	logic [CNT_W-1:0]   cnt_inc;
	logic               rate_less;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign rd_entry = entry_t'(rdata);

	// target slot must exist and hold an entry
	assign tgt_ok = (cmd.target_slot < SLOT_NUM) ? valid_q[cmd.target_slot] : 1'b0;

	// key compare runs in the cycle after the read address
	assign scan_cmp = cmp_vld_s1 && (state_q == ST_SCAN || state_q == ST_SCAN_LAST);
	assign hit_now  = scan_cmp && valid_q[cmp_idx_s1] && (rd_entry.key == cmd_q.key);
	assign free_now = scan_cmp && !valid_q[cmp_idx_s1];

	// age floored at 1, also when time seems to run backwards
	assign age_d = (cmd_q.now > rd_entry.stamp) ? (cmd_q.now - rd_entry.stamp) : TIME_W'(1);

	// steps 0,1: candidate count times best age; steps 2,3: best count times candidate age
	assign mul_a    = step_q[1] ? best_cnt_q : cand_cnt_q;
	assign mul_bsrc = step_q[1] ? cand_age_q : best_age_q;
	assign mul_b    = step_q[0] ? mul_bsrc[TIME_W-1:HALF_W] : mul_bsrc[HALF_W-1:0];
	assign prod_d   = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign wide_sum = WIDE_W'(lo_q) + {prod_q, {HALF_W{1'b0}}};

	assign rate_less = (p1_q < p2_q);
	assign cnt_inc   = (rd_entry.cnt == '1) ? rd_entry.cnt : rd_entry.cnt + CNT_W'(1);

	urc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ctl.ram_we),
		.waddr(ctl.ram_waddr),
		.wdata(ctl.ram_wdata),
		.re   (ctl.ram_re),
		.raddr(ctl.ram_raddr),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.kind == KIND_RECYCLE) begin
						state_d = tgt_ok ? ST_RC_RD : ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit_now) begin
					state_d = ST_IDLE;
				end else if (idx_q == LAST_SLOT) begin
					state_d = ST_SCAN_LAST;
				end
			end
			ST_SCAN_LAST: begin
				if (hit_now) begin
					state_d = ST_IDLE;
				end else if (free_found_q || free_now) begin
					state_d = ST_INS;
				end else begin
					state_d = ST_EV_RD;
				end
			end
			ST_INS:    state_d = ST_IDLE;
			ST_EV_RD:  state_d = ST_EV_AGE;
			ST_EV_AGE: state_d = (idx_q == '0) ? ST_EV_RD : ST_EV_MUL;
			ST_EV_MUL: begin
				if (step_q == MUL_STEPS) begin
					state_d = ST_EV_CMP;
				end
			end
			ST_EV_CMP: state_d = (idx_q == LAST_SLOT) ? ST_INS : ST_EV_RD;
			ST_RC_RD:  state_d = ST_RC_WR;
			ST_RC_WR:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs: RAM control and the result to register
	always_comb begin
		ctl = '0;
		ctl.res.slot = cmd_q.target_slot;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.kind == KIND_RECYCLE && !tgt_ok) begin
					ctl.finish     = 1'b1;
					ctl.res.slot   = cmd.target_slot;
					ctl.res.status = STATUS_BAD_SLT;
				end
			end
			ST_SCAN: begin
				ctl.ram_re    = 1'b1;
				ctl.ram_raddr = idx_q;
				if (hit_now) begin
					ctl.finish   = 1'b1;
					ctl.res.hit  = 1'b1;
					ctl.res.slot = cmp_idx_s1;
				end
			end
			ST_SCAN_LAST: begin
				if (hit_now) begin
					ctl.finish   = 1'b1;
					ctl.res.hit  = 1'b1;
					ctl.res.slot = cmp_idx_s1;
				end
			end
			ST_INS: begin
				ctl.ram_we          = 1'b1;
				ctl.ram_waddr       = ev_q ? best_idx_q : ins_slot_q;
				ctl.ram_wdata.key   = cmd_q.key;
				ctl.ram_wdata.cnt   = '0;
				ctl.ram_wdata.stamp = cmd_q.now;
				ctl.finish          = 1'b1;
				ctl.res.slot        = ctl.ram_waddr;
				ctl.res.evicted     = ev_q;
				ctl.res.evicted_key = ev_q ? best_key_q : '0;
			end
			ST_EV_RD: begin
				ctl.ram_re    = 1'b1;
				ctl.ram_raddr = idx_q;
			end
			ST_RC_RD: begin
				ctl.ram_re    = 1'b1;
				ctl.ram_raddr = cmd_q.target_slot;
			end
			ST_RC_WR: begin
				ctl.ram_we          = 1'b1;
				ctl.ram_waddr       = cmd_q.target_slot;
				ctl.ram_wdata.key   = rd_entry.key;
				ctl.ram_wdata.cnt   = cnt_inc;
				ctl.ram_wdata.stamp = cmd_q.now;
				ctl.finish          = 1'b1;
			end
			default: begin
				ctl = ctl;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			ev_q         <= 1'b0;
			idx_q        <= '0;
			step_q       <= '0;
			done         <= 1'b0;
		end else begin
			state_q    <= state_d;
			done       <= ctl.finish;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_INS) begin
				valid_q[ctl.ram_waddr] <= 1'b1;
			end
			if (accept) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				ev_q         <= 1'b0;
			end
			// advance the scan address
			if (state_q == ST_SCAN && idx_q != LAST_SLOT) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (free_now && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (state_q == ST_SCAN_LAST && state_d == ST_EV_RD) begin
				ev_q  <= 1'b1;
				idx_q <= '0;
			end
			if (state_q == ST_EV_AGE && idx_q == '0) begin
				idx_q <= SLOT_W'(1);
			end
			if (state_q == ST_EV_CMP && idx_q != LAST_SLOT) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (state_q == ST_EV_MUL) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// payload and datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (ctl.finish) begin
			result <= ctl.res;
		end
		cmp_idx_s1 <= idx_q;
		if (free_now && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (state_q == ST_SCAN_LAST) begin
			ins_slot_q <= free_found_q ? free_idx_q : cmp_idx_s1;
		end
		if (state_q == ST_EV_AGE) begin
			cand_key_q <= rd_entry.key;
			cand_cnt_q <= rd_entry.cnt;
			cand_age_q <= age_d;
			// slot zero seeds the search
			if (idx_q == '0) begin
				best_idx_q <= '0;
				best_key_q <= rd_entry.key;
				best_cnt_q <= rd_entry.cnt;
				best_age_q <= age_d;
			end
		end
		if (state_q == ST_EV_MUL) begin
			prod_q <= prod_d;
			// fold in the product of the previous step
			case (step_q)
				3'd1, 3'd3: lo_q <= prod_q;
				3'd2:       p1_q <= wide_sum;
				3'd4:       p2_q <= wide_sum;
				default:    lo_q <= lo_q;
			endcase
		end
		// strictly lower rate wins, so a tie keeps the lower slot
		if (state_q == ST_EV_CMP && rate_less) begin
			best_idx_q <= idx_q;
			best_key_q <= cand_key_q;
			best_cnt_q <= cand_cnt_q;
			best_age_q <= cand_age_q;
		end
	end

endmodule

@@ rtl/core/urc_checker.sv @@
// Port-level checks for the use-rate cache top level, and the bind that attaches them.
// Depends on urc_pkg.
module urc_checker
	import urc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// an accepted item either starts work or finishes at once
	a_accept_then_work: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither busy nor finished");

	// work ends only with a result strobe
	a_busy_falls_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (!result.hit && !result.evicted))
		else $error("ignored recycle reports a hit or an eviction");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (!result.evicted && result.evicted_key == '0))
		else $error("hit reports an eviction");

endmodule

bind usage_rate_cache_replacement_top urc_checker u_urc_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

@@ dv/testbench.sv @@
// Self-checking testbench for usage_rate_cache_replacement_top: directed and random items.
// A tracker class predicts every result, and plain tasks drive the command port.
// Depends on urc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
	import urc_pkg::*;

	// The slowest item is a full-cache insert, and the sender may idle between items.
	// Allow many times the slowest item before declaring a hang.
	localparam int QUIET_LIMIT  = 4000;
	// Cycles to wait after the last result so that a stray extra strobe is caught.
	localparam int DRAIN_CYCLES = 300;
	localparam int POOL_SIZE    = 40;

	// Tracks the cache contents and predicts each result. Expected results are queued in
	// acceptance order and matched against strobed results.
	class cache_tracker;
		bit                entry_valid[ENTRIES];
		logic [KEY_W-1:0]  entry_key[ENTRIES];
		logic [CNT_W-1:0]  use_count[ENTRIES];
		logic [TIME_W-1:0] last_use[ENTRIES];
		result_t           expected_q[$];
		int                errors;

		function new();
			foreach (entry_valid[i]) entry_valid[i] = 1'b0;
			errors = 0;
		endfunction

		// The age is floored at 1. This also covers a clock that ran backwards.
		function logic [TIME_W-1:0] age_of(int s, logic [TIME_W-1:0] t);
			if (t <= last_use[s])
				return TIME_W'(1);
			return t - last_use[s];
		endfunction

		// count_a/age_a < count_b/age_b, compared exactly by cross-multiplication
		function bit rate_below(int a, int b, logic [TIME_W-1:0] t);
			logic [WIDE_W-1:0] lhs;
			logic [WIDE_W-1:0] rhs;
			lhs = WIDE_W'(use_count[a]) * WIDE_W'(age_of(b, t));
			rhs = WIDE_W'(use_count[b]) * WIDE_W'(age_of(a, t));
			return lhs < rhs;
		endfunction

		function void predict(cmd_t c);
			result_t r;
			int      pick;
			bit      found;
			r = '0;
			r.status = STATUS_OK;
			if (c.kind == KIND_RECYCLE) begin
				r.slot = c.target_slot;
				if (c.target_slot >= SLOT_NUM || !entry_valid[c.target_slot]) begin
					r.status = STATUS_BAD_SLT;
				end else begin
					// The count sticks at all ones.
					if (use_count[c.target_slot] != '1)
						use_count[c.target_slot] = use_count[c.target_slot] + 1'b1;
					last_use[c.target_slot] = c.now;
				end
			end else begin
				found = 1'b0;
				for (int s = 0; s < ENTRIES; s++) begin
					if (!found && entry_valid[s] && entry_key[s] == c.key) begin
						found = 1'b1;
						r.hit = 1'b1;
						r.slot = SLOT_W'(s);
					end
				end
				if (!found) begin
					pick = -1;
					for (int s = 0; s < ENTRIES; s++)
						if (pick < 0 && !entry_valid[s])
							pick = s;
					if (pick < 0) begin
						// Cache full: evict the lowest rate. On a tie the lower slot stays picked.
						pick = 0;
						for (int s = 1; s < ENTRIES; s++)
							if (rate_below(s, pick, c.now))
								pick = s;
						r.evicted = 1'b1;
						r.evicted_key = entry_key[pick];
					end
					entry_valid[pick] = 1'b1;
					entry_key[pick] = c.key;
					use_count[pick] = '0;
					last_use[pick] = c.now;
					r.slot = SLOT_W'(pick);
				end
			end
			expected_q.push_back(r);
		endfunction

		function void diff_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no item outstanding, expected none, actual %h",
					$time, r);
				return;
			end
			e = expected_q.pop_front();
			diff_field("hit", KEY_W'(e.hit), KEY_W'(r.hit));
			diff_field("slot", KEY_W'(e.slot), KEY_W'(r.slot));
			diff_field("evicted", KEY_W'(e.evicted), KEY_W'(r.evicted));
			diff_field("evicted_key", e.evicted_key, r.evicted_key);
			diff_field("status", KEY_W'(e.status), KEY_W'(r.status));
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				errors += expected_q.size();
				$display("%0t: results missing, expected %0d more, actual 0", $time,
					expected_q.size());
			end
		endfunction
	endclass

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	cache_tracker      tracker = new();
	int                quiet_cycles = 0;
	logic [TIME_W-1:0] clock_now;
	logic [KEY_W-1:0]  key_pool[POOL_SIZE];

	usage_rate_cache_replacement_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// Results cannot be held off. Sample each strobe at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(result);
	end

	// Watchdog: restart the count on every accepted item or result.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL usage_rate_cache_replacement_top");
				$finish;
			end
		end
	end

	// Present one item and hold it until the block takes it. An item is taken at an edge
	// where start is high and busy was low. start stays high, so the next call can follow
	// back to back.
	task automatic send_item(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		tracker.predict(c);
	endtask

	task automatic issue(logic kind, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] tslot,
			logic [TIME_W-1:0] t);
		cmd_t c;
		c.kind = kind;
		c.key = key;
		c.target_slot = tslot;
		c.now = t;
		send_item(c);
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop start and wait until every outstanding result has come back.
	task automatic hold_until_drained();
		start <= 1'b0;
		while (tracker.expected_q.size() != 0) @(posedge clk);
	endtask

	// Advance the time stamp. Usually take small steps, so that zero ages come up too.
	// Sometimes take a large jump. Now and then take a random value, which may go backwards.
	function automatic void bump_clock();
		logic [TIME_W:0] next;
		int              r;
		r = $urandom_range(99);
		if (r < 3)
			next = {1'b0, 16'($urandom), 32'($urandom)};
		else if (r < 10)
			next = {1'b0, clock_now} + {17'b0, 32'($urandom)};
		else
			next = {1'b0, clock_now} + (TIME_W+1)'($urandom_range(40));
		clock_now = next[TIME_W] ? '1 : next[TIME_W-1:0];
	endfunction

	// Random item. Most items are lookups of pooled keys, so that both hits and evictions
	// occur, or recycles of live slots. These bias the use counts. The rest is noise: fresh
	// keys and recycles of any slot code, out of range ones included. Fields that the block
	// ignores still carry random values.
	task automatic random_item(int pool_span);
		int                r;
		int                s;
		logic [KEY_W-1:0]  k;
		logic [SLOT_W-1:0] ts;
		bump_clock();
		r = $urandom_range(99);
		k = $urandom;
		ts = SLOT_W'($urandom);
		if (r < 50) begin
			issue(KIND_LOOKUP, key_pool[$urandom_range(pool_span - 1)], ts, clock_now);
		end else if (r < 58) begin
			issue(KIND_LOOKUP, k, ts, clock_now);
		end else if (r < 90) begin
			// Find a live slot, starting from a random one.
			s = $urandom_range(ENTRIES - 1);
			for (int i = 0; i < ENTRIES && !tracker.entry_valid[s]; i++)
				s = (s + 1) % ENTRIES;
			issue(KIND_RECYCLE, k, SLOT_W'(s), clock_now);
		end else begin
			issue(KIND_RECYCLE, k, SLOT_W'($urandom_range(31)), clock_now);
		end
	endtask

	task automatic random_phase(int count, int pool_span, int gap_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < gap_pct)
				idle_for($urandom_range(1, 12));
			random_item(pool_span);
		end
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: recycle of an empty slot, recycle of an out of range slot, inserts and
		// hits at the key extremes, a zero age, the largest time stamp, a clock that runs
		// backwards, and the last slot code while it is still empty.
		issue(KIND_RECYCLE, '0, 5'd0, '0);
		issue(KIND_RECYCLE, '1, 5'd31, '1);
		issue(KIND_LOOKUP, '0, 5'd31, '0);
		issue(KIND_LOOKUP, '1, 5'd0, 48'd1);
		issue(KIND_LOOKUP, '0, 5'd0, 48'd2);
		issue(KIND_LOOKUP, '1, 5'd0, 48'd3);
		issue(KIND_RECYCLE, 32'h1234_5678, 5'd0, 48'd10);
		issue(KIND_RECYCLE, 32'h8765_4321, 5'd0, 48'd10);
		idle_for(5);
		issue(KIND_RECYCLE, '0, 5'd1, '1);
		issue(KIND_LOOKUP, 32'hA5A5_A5A5, 5'd21, '1);
		issue(KIND_RECYCLE, '1, 5'd1, '0);
		issue(KIND_RECYCLE, '0, 5'd30, 48'd20);
		issue(KIND_RECYCLE, '0, 5'd29, 48'd21);
		issue(KIND_LOOKUP, 32'h5A5A_5A5A, 5'd10, 48'h5555_5555_5555);
		issue(KIND_LOOKUP, 32'h0000_0001, 5'd5, 48'hAAAA_AAAA_AAAA);
		issue(KIND_RECYCLE, '1, 5'd2, 48'hAAAA_AAAA_AAAA);
		issue(KIND_LOOKUP, 32'hA5A5_A5A5, 5'd0, 48'hAAAA_AAAA_AAAB);
		issue(KIND_RECYCLE, '0, 5'd3, 48'hAAAA_AAAA_AAAC);
		// Use-count saturation needs 2^32 recycles of one entry. That is out of reach in
		// simulation, but the tracker still models it.
		hold_until_drained();

		// Random: fill the cache and churn it with gaps, then pause until it drains. Then
		// run a wider key pool with gaps, and finally run back to back with no idling.
		clock_now = 48'd1000;
		random_phase(350, 34, 30);
		hold_until_drained();
		idle_for($urandom_range(1, 12));
		random_phase(250, POOL_SIZE, 20);
		random_phase(100, POOL_SIZE, 0);

		start <= 1'b0;
		while (tracker.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.errors == 0)
			$display("PASS usage_rate_cache_replacement_top");
		else
			$display("FAIL usage_rate_cache_replacement_top");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/urc_pkg.sv
rtl/core/urc_ram.sv
rtl/core/usage_rate_cache_replacement_top.sv
rtl/core/urc_checker.sv
dv/testbench.sv
